### src/y2r_pkg.sv
// y2r_pkg: types, fixed-point constants and helper functions for the
// yuyv pair to rgb565 converter; no dependencies
package y2r_pkg;

   typedef enum logic [1:0] {
      CHAN_ALL   = 2'd0,
      CHAN_RED   = 2'd1,
      CHAN_GREEN = 2'd2,
      CHAN_BLUE  = 2'd3
   } chan_sel_type;

   localparam int FRAC_BITS = 12;
   localparam int PROD_W    = 22;
   localparam int SUM_W     = 23;

   // bt.601 coefficients, signed q12
   localparam logic signed [PROD_W-1:0] K_B_U = PROD_W'(7258);
   localparam logic signed [PROD_W-1:0] K_G_U = PROD_W'(1409);
   localparam logic signed [PROD_W-1:0] K_G_V = PROD_W'(2925);
   localparam logic signed [PROD_W-1:0] K_R_V = PROD_W'(5743);

   localparam logic [15:0] MASK_ALL   = 16'hffff;
   localparam logic [15:0] MASK_RED   = 16'hf800;
   localparam logic [15:0] MASK_GREEN = 16'h07e0;
   localparam logic [15:0] MASK_BLUE  = 16'h001f;

   // chroma byte cut to 5 bits, re-expanded and centered
   function automatic logic signed [PROD_W-1:0] chroma_offset(input logic [4:0] c5);
      logic signed [8:0] d;
      d = $signed({1'b0, c5, 3'b000}) - 9'sd128;
      return PROD_W'(d);
   endfunction

   // luma in q12: y6 * 4 * 4096
   function automatic logic signed [SUM_W-1:0] luma_q12(input logic [5:0] y6);
      return $signed(SUM_W'({y6, 14'b0}));
   endfunction

   // floor a q12 sum and clamp to 0..255
   function automatic logic [7:0] q12_to_byte(input logic signed [SUM_W-1:0] q);
      logic [7:0] res;
      if (q[SUM_W-1]) begin
         res = 8'd0;
      end else if (q[SUM_W-2:FRAC_BITS+8] != '0) begin
         res = 8'hff;
      end else begin
         res = q[FRAC_BITS+7:FRAC_BITS];
      end
      return res;
   endfunction

   function automatic logic [15:0] pack565(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   function automatic logic [15:0] chan_mask(input chan_sel_type sel);
      logic [15:0] m;
      case (sel)
         CHAN_ALL:   m = MASK_ALL;
         CHAN_RED:   m = MASK_RED;
         CHAN_GREEN: m = MASK_GREEN;
         CHAN_BLUE:  m = MASK_BLUE;
         default:    m = MASK_ALL;
      endcase
      return m;
   endfunction

endpackage

### src/yuv422_to_rgb565_masked.sv
// yuv422_to_rgb565_masked: four-stage pipelined yuyv pair to rgb565 converter
// with a channel mask; depends on y2r_pkg
//
// One yuyv pixel pair (two 16-bit camera words, Y high byte, U or V low byte)
// enters per clock while req_stall is low and leaves as two masked rgb565 words.
// The pipeline is quantize, chroma multiply, sum/floor/clamp, pack/mask; each
// stage holds its item while the next is full, so a stall on rsp only stops
// the stages behind a full one and bubbles are squeezed out. Throughput is one
// pair per cycle while rsp is not stalled. The channel select register is
// written through the csr port (always ready) and should change only while no
// item is in flight.
module yuv422_to_rgb565_masked (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_pixel_first,
   input  logic [15:0] req_pixel_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_rgb_first,
   output logic [15:0] rsp_rgb_second,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_channel_select
);
   import y2r_pkg::*;

   chan_sel_type channel_select_ff, channel_select_in;

   logic rdy1, rdy2, rdy3, rdy4;

   // stage 1: quantized fields
   logic       s1_valid_ff, s1_valid_in;
   logic [5:0] s1_y0_ff, s1_y1_ff;
   logic [4:0] s1_u_ff, s1_v_ff;

   // stage 2: chroma products
   logic                     s2_valid_ff, s2_valid_in;
   logic [5:0]               s2_y0_ff, s2_y1_ff;
   logic signed [PROD_W-1:0] s2_pb_ff, s2_pgu_ff, s2_pgv_ff, s2_pr_ff;
   logic signed [PROD_W-1:0] s2_pb_in, s2_pgu_in, s2_pgv_in, s2_pr_in;

   // stage 3: clamped bytes
   logic       s3_valid_ff, s3_valid_in;
   logic [7:0] s3_r0_ff, s3_g0_ff, s3_b0_ff, s3_r1_ff, s3_g1_ff, s3_b1_ff;
   logic [7:0] s3_r0_in, s3_g0_in, s3_b0_in, s3_r1_in, s3_g1_in, s3_b1_in;

   // stage 4: output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_rgb_first_ff, rsp_rgb_second_ff;

   assign rdy4      = !rsp_valid_ff || !rsp_stall;
   assign rdy3      = !s3_valid_ff || rdy4;
   assign rdy2      = !s2_valid_ff || rdy3;
   assign rdy1      = !s1_valid_ff || rdy2;
   assign req_stall = !rdy1;
   assign csr_ready = 1'b1;

   assign channel_select_in = csr_valid ? chan_sel_type'(csr_channel_select)
                                        : channel_select_ff;

   assign s1_valid_in  = rdy1 ? req_valid : s1_valid_ff;
   assign s2_valid_in  = rdy2 ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in  = rdy3 ? s2_valid_ff : s3_valid_ff;
   assign rsp_valid_in = rdy4 ? s3_valid_ff : rsp_valid_ff;

   always_comb begin
      s2_pb_in  = chroma_offset(s1_u_ff) * K_B_U;
      s2_pgu_in = chroma_offset(s1_u_ff) * K_G_U;
      s2_pgv_in = chroma_offset(s1_v_ff) * K_G_V;
      s2_pr_in  = chroma_offset(s1_v_ff) * K_R_V;
   end

   always_comb begin
      s3_b0_in = q12_to_byte(luma_q12(s2_y0_ff) + SUM_W'(s2_pb_ff));
      s3_g0_in = q12_to_byte(luma_q12(s2_y0_ff) - SUM_W'(s2_pgu_ff) - SUM_W'(s2_pgv_ff));
      s3_r0_in = q12_to_byte(luma_q12(s2_y0_ff) + SUM_W'(s2_pr_ff));
      s3_b1_in = q12_to_byte(luma_q12(s2_y1_ff) + SUM_W'(s2_pb_ff));
      s3_g1_in = q12_to_byte(luma_q12(s2_y1_ff) - SUM_W'(s2_pgu_ff) - SUM_W'(s2_pgv_ff));
      s3_r1_in = q12_to_byte(luma_q12(s2_y1_ff) + SUM_W'(s2_pr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         channel_select_ff <= CHAN_ALL;
         s1_valid_ff       <= 1'b0;
         s2_valid_ff       <= 1'b0;
         s3_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         channel_select_ff <= channel_select_in;
         s1_valid_ff       <= s1_valid_in;
         s2_valid_ff       <= s2_valid_in;
         s3_valid_ff       <= s3_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && req_valid) begin
         s1_y0_ff <= req_pixel_first[15:10];
         s1_y1_ff <= req_pixel_second[15:10];
         s1_u_ff  <= req_pixel_first[7:3];
         s1_v_ff  <= req_pixel_second[7:3];
      end
      if (rdy2 && s1_valid_ff) begin
         s2_y0_ff  <= s1_y0_ff;
         s2_y1_ff  <= s1_y1_ff;
         s2_pb_ff  <= s2_pb_in;
         s2_pgu_ff <= s2_pgu_in;
         s2_pgv_ff <= s2_pgv_in;
         s2_pr_ff  <= s2_pr_in;
      end
      if (rdy3 && s2_valid_ff) begin
         s3_r0_ff <= s3_r0_in;
         s3_g0_ff <= s3_g0_in;
         s3_b0_ff <= s3_b0_in;
         s3_r1_ff <= s3_r1_in;
         s3_g1_ff <= s3_g1_in;
         s3_b1_ff <= s3_b1_in;
      end
      if (rdy4 && s3_valid_ff) begin
         rsp_rgb_first_ff  <= pack565(s3_r0_ff, s3_g0_ff, s3_b0_ff)
                              & chan_mask(channel_select_ff);
         rsp_rgb_second_ff <= pack565(s3_r1_ff, s3_g1_ff, s3_b1_ff)
                              & chan_mask(channel_select_ff);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rgb_first  = rsp_rgb_first_ff;
   assign rsp_rgb_second = rsp_rgb_second_ff;

   // an accepted item always lands in stage 1
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted item missing from stage 1");

   // a full stage 3 behind a stalled output keeps its item
   a_s3_holds: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && rsp_valid_ff && rsp_stall |=> s3_valid_ff && $stable(s3_r0_ff)
         && $stable(s3_g1_ff))
      else $error("stage 3 item lost under stall");

   // a result appears only when stage 3 held an item
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s3_valid_ff))
      else $error("result without a source item");

endmodule

### sim/tb_top.sv
// tb_top: self-checking testbench for yuv422_to_rgb565_masked, directed table
// then random pixel pairs under all four channel masks with random backpressure
// depends on y2r_pkg and the converter rtl
module tb_top;
   import y2r_pkg::*;

   localparam int N_DIR       = 20;
   localparam int N_PHASES    = 8;
   localparam int PHASE_ITEMS = 129;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_WAIT  = 16;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [15:0] first;
      logic [15:0] second;
   } rgb_pair_type;

   typedef struct packed {
      logic [15:0] pf;
      logic [15:0] ps;
      logic        typed;
      logic [15:0] ef;
      logic [15:0] es;
   } dir_row_type;

   // typed rows: black, white, mid gray, mixed luma
   localparam dir_row_type DIR_ROWS [N_DIR] = '{
      '{16'h0080, 16'h0080, 1'b1, 16'h0000, 16'h0000},
      '{16'hff80, 16'hff80, 1'b1, 16'hffff, 16'hffff},
      '{16'h8080, 16'h8080, 1'b1, 16'h8410, 16'h8410},
      '{16'hff80, 16'h0080, 1'b1, 16'hffff, 16'h0000},
      '{16'h0080, 16'hff80, 1'b1, 16'h0000, 16'hffff},
      '{16'h0000, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{16'hffff, 16'hffff, 1'b0, 16'h0000, 16'h0000},
      '{16'hffff, 16'h0000, 1'b0, 16'h0000, 16'h0000},
      '{16'h0000, 16'hffff, 1'b0, 16'h0000, 16'h0000},
      '{16'h00ff, 16'h00ff, 1'b0, 16'h0000, 16'h0000},
      '{16'hff00, 16'hff00, 1'b0, 16'h0000, 16'h0000},
      '{16'h8000, 16'h80ff, 1'b0, 16'h0000, 16'h0000},
      '{16'h80ff, 16'h8000, 1'b0, 16'h0000, 16'h0000},
      '{16'hff00, 16'h00ff, 1'b0, 16'h0000, 16'h0000},
      '{16'h5555, 16'haaaa, 1'b0, 16'h0000, 16'h0000},
      '{16'haaaa, 16'h5555, 1'b0, 16'h0000, 16'h0000},
      '{16'h0307, 16'h0307, 1'b0, 16'h0000, 16'h0000},
      '{16'hfcf8, 16'h04f8, 1'b0, 16'h0000, 16'h0000},
      '{16'h1234, 16'hedcb, 1'b0, 16'h0000, 16'h0000},
      '{16'h7f7f, 16'h8181, 1'b0, 16'h0000, 16'h0000}
   };

   localparam chan_sel_type PHASE_ORDER [4] = '{CHAN_BLUE, CHAN_RED, CHAN_GREEN, CHAN_ALL};

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_pixel_first;
   logic [15:0] req_pixel_second;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_rgb_first;
   logic [15:0] rsp_rgb_second;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_channel_select;

   rgb_pair_type rgb_expect_q[$];
   chan_sel_type cur_sel;
   chan_sel_type phase_sel;
   int           mismatches;
   int           pairs_sent;
   int           pairs_checked;
   int           cycle_count;
   int           stall_left;
   int           roll;
   bit           calm;
   bit           hold_req;

   yuv422_to_rgb565_masked u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_pixel_first    (req_pixel_first),
      .req_pixel_second   (req_pixel_second),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rgb_first      (rsp_rgb_first),
      .rsp_rgb_second     (rsp_rgb_second),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_channel_select (csr_channel_select)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // floor a q12 sum and clamp to one byte
   function automatic logic [7:0] clamp_channel(input int q);
      int w;
      w = q >>> 12;
      if (w < 0) begin
         return 8'd0;
      end else if (w > 255) begin
         return 8'd255;
      end
      return w[7:0];
   endfunction

   function automatic logic [15:0] pixel_rgb565(input logic [7:0] y8, input logic [7:0] u8,
                                                input logic [7:0] v8);
      int y, du, dv;
      logic [7:0] r, g, b;
      y  = int'(y8[7:2]) * 4;
      du = int'(u8[7:3]) * 8 - 128;
      dv = int'(v8[7:3]) * 8 - 128;
      b  = clamp_channel(y * 4096 + 7258 * du);
      g  = clamp_channel(y * 4096 - 1409 * du - 2925 * dv);
      r  = clamp_channel(y * 4096 + 5743 * dv);
      return {r[7:3], g[7:2], b[7:3]};
   endfunction

   function automatic rgb_pair_type predict_pair(input logic [15:0] pf, input logic [15:0] ps,
                                                 input chan_sel_type sel);
      logic [15:0]  m;
      rgb_pair_type res;
      case (sel)
         CHAN_RED:   m = MASK_RED;
         CHAN_GREEN: m = MASK_GREEN;
         CHAN_BLUE:  m = MASK_BLUE;
         default:    m = MASK_ALL;
      endcase
      res.first  = pixel_rgb565(pf[15:8], pf[7:0], ps[7:0]) & m;
      res.second = pixel_rgb565(ps[15:8], pf[7:0], ps[7:0]) & m;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end else if (r < 98) begin
         return $urandom_range(4, 8);
      end
      return $urandom_range(10, 30);
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 8'h00;
         1: return 8'hff;
         2: return 8'h80;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("mismatch %s: got %h expected %h (sel %s)", what, got, want, cur_sel.name());
      mismatches++;
   endtask

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_pair(input logic [15:0] pf, input logic [15:0] ps, input logic typed,
                            input logic [15:0] ef, input logic [15:0] es);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_pixel_first  <= pf;
      req_pixel_second <= ps;
      do @(posedge clock); while (req_stall);
      if (typed) begin
         rgb_expect_q.push_back('{first: ef, second: es});
      end else begin
         rgb_expect_q.push_back(predict_pair(pf, ps, cur_sel));
      end
      pairs_sent++;
      @(negedge clock);
   endtask

   task automatic write_channel_select(input chan_sel_type sel);
      req_valid <= 1'b0;
      while (rgb_expect_q.size() != 0) @(posedge clock);
      @(negedge clock);
      csr_valid          <= 1'b1;
      csr_channel_select <= sel;
      do @(posedge clock); while (!csr_ready);
      cur_sel = sel;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: random stall bursts plus one long hold on request
   initial begin
      rsp_stall  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (!calm) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
               stall_left = $urandom_range(1, 3);
            end else if (roll < 18) begin
               stall_left = $urandom_range(10, 40);
            end
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   always @(posedge clock) begin
      rgb_pair_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rgb_expect_q.size() == 0) begin
            report_mismatch("unexpected item", rsp_rgb_first, 16'h0000);
         end else begin
            want = rgb_expect_q.pop_front();
            if (rsp_rgb_first !== want.first) begin
               report_mismatch("rgb_first", rsp_rgb_first, want.first);
            end
            if (rsp_rgb_second !== want.second) begin
               report_mismatch("rgb_second", rsp_rgb_second, want.second);
            end
            pairs_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
                  rgb_expect_q.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_pixel_first    = 16'h0000;
      req_pixel_second   = 16'h0000;
      csr_valid          = 1'b0;
      csr_channel_select = CHAN_ALL;
      cur_sel            = CHAN_ALL;
      calm               = 1'b0;
      hold_req           = 1'b0;
      mismatches         = 0;
      pairs_sent         = 0;
      pairs_checked      = 0;
      cycle_count        = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < N_DIR; i++) begin
         send_pair(DIR_ROWS[i].pf, DIR_ROWS[i].ps, DIR_ROWS[i].typed,
                   DIR_ROWS[i].ef, DIR_ROWS[i].es);
      end

      for (int p = 0; p < N_PHASES; p++) begin
         phase_sel = (p < 4) ? PHASE_ORDER[p] : chan_sel_type'($urandom_range(0, 3));
         write_channel_select(phase_sel);
         calm = (p == 3);
         if (p == 1) begin
            hold_req = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            send_pair({pick_byte(), pick_byte()}, {pick_byte(), pick_byte()}, 1'b0,
                      16'h0000, 16'h0000);
         end
      end

      req_valid <= 1'b0;
      while (rgb_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("sent %0d pixel pairs, checked %0d results", pairs_sent, pairs_checked);
      $display("covered all four channel masks, random gaps, stall bursts and a long hold");
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### sim.f
src/y2r_pkg.sv
src/yuv422_to_rgb565_masked.sv
sim/tb_top.sv
